// ===== rtl/whp_pkg.sv =====
// Shared types and constants of the RIFF/WAVE header parser.
package whp_pkg;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;
   localparam logic [1:0] ST_EARLY   = 2'd3;

   localparam logic [0:0] CSR_MIN_RATE = 1'b0;
   localparam logic [0:0] CSR_MAX_RATE = 1'b1;

   localparam logic [31:0] MIN_RATE_RESET = 32'd1378;
   localparam logic [31:0] MAX_RATE_RESET = 32'd96000;
   localparam logic [31:0] RIFF_MIN_LEN   = 32'd36;
   localparam logic [31:0] FMT_BASE_LEN   = 32'd16;

   localparam logic [15:0] FMT_PCM    = 16'h0001;
   localparam logic [15:0] FMT_ALAW_A = 16'h0006;
   localparam logic [15:0] FMT_ALAW_B = 16'h0102;
   localparam logic [15:0] FMT_ULAW_A = 16'h0007;
   localparam logic [15:0] FMT_ULAW_B = 16'h0101;

   localparam logic [31:0] TAG_RIFF = 32'h46464952;
   localparam logic [31:0] TAG_WAVE = 32'h45564157;
   localparam logic [31:0] TAG_FMT  = 32'h20746D66;
   localparam logic [31:0] TAG_DATA = 32'h61746164;

   localparam int QDEPTH = 2;

   typedef enum logic [5:0] {
      PH_RIFF      = 6'b000001,
      PH_FMT       = 6'b000010,
      PH_FMT_SKIP  = 6'b000100,
      PH_CHUNK_HDR = 6'b001000,
      PH_CHUNK_SKIP= 6'b010000,
      PH_DONE      = 6'b100000
   } phase_type;

   // Word passed from the front parser to the result stage.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] format_code;
      logic [1:0]  channels;
      logic [31:0] rate;
      logic [4:0]  bits;
      logic [31:0] offset;
      logic [31:0] length;
   } result_type;

   function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] i);
      tag_byte = tag[8*i +: 8];
   endfunction

endpackage

// ===== rtl/whp_front.sv =====
// Byte-level header parser: walks the file and produces one raw result word.
module whp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   input  logic [31:0]         min_rate,
   input  logic [31:0]         max_rate,
   output logic                res_valid,
   output whp_pkg::result_type res_word,
   input  logic                res_full
);
   whp_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  idx_ff, idx_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] fmt_ff, fmt_in;
   logic [15:0] ch_ff, ch_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] pos_ff, pos_in;
   logic        bad_ff, bad_in;
   // Checks that do not depend on the final byte are registered early.
   logic        rate_bad_ff, rate_bad_in;
   logic        brate_bad_ff, brate_bad_in;
   logic [31:0] prod_w;

   logic        fire, produced;
   logic [1:0]  st;
   logic [15:0] bits_w;
   logic [2:0]  width_w;
   logic [3:0]  align_w;
   logic        fmt_known;
   logic [31:0] len_w;
   logic [1:0]  rem;

   assign in_stall = res_full;
   assign fire = in_valid && !res_full;

   // Block align is 1 to 4 whenever the byte-rate check decides, so a shift-add is enough.
   assign prod_w = (align_ff[0] ? rate_ff : 32'd0) +
      (align_ff[1] ? {rate_ff[30:0], 1'b0} : 32'd0) +
      (align_ff[2] ? {rate_ff[29:0], 2'b00} : 32'd0);

   always_comb begin
      phase_in = phase_ff; idx_in = idx_ff; len_in = len_ff; fmt_in = fmt_ff;
      ch_in = ch_ff; rate_in = rate_ff; brate_in = brate_ff; align_in = align_ff;
      skip_in = skip_ff; bad_in = bad_ff;
      rate_bad_in = (rate_ff < min_rate) || (rate_ff > max_rate);
      brate_bad_in = brate_ff != prod_w;
      pos_in = pos_ff + 32'd1;
      asm_in = {data_byte, asm_ff[31:8]};
      produced = 1'b0;
      st = whp_pkg::ST_OK;
      bits_w = asm_in[31:16];
      fmt_known = (fmt_ff == whp_pkg::FMT_PCM) || (fmt_ff == whp_pkg::FMT_ALAW_A) ||
         (fmt_ff == whp_pkg::FMT_ALAW_B) || (fmt_ff == whp_pkg::FMT_ULAW_A) ||
         (fmt_ff == whp_pkg::FMT_ULAW_B);
      width_w = 3'd0;
      align_w = 4'd0;
      len_w = len_ff;
      rem = 2'd0;
      case (phase_ff)
         whp_pkg::PH_RIFF: begin
            if (idx_ff < 5'd4 && data_byte != whp_pkg::tag_byte(whp_pkg::TAG_RIFF, idx_ff[1:0]))
               bad_in = 1'b1;
            if (idx_ff >= 5'd8 && data_byte != whp_pkg::tag_byte(whp_pkg::TAG_WAVE, idx_ff[1:0]))
               bad_in = 1'b1;
            if (idx_ff == 5'd7 && asm_in < whp_pkg::RIFF_MIN_LEN) bad_in = 1'b1;
            if (idx_ff >= 5'd11) begin
               idx_in = 5'd0;
               if (bad_in) begin
                  produced = 1'b1; st = whp_pkg::ST_INVALID;
               end else begin
                  phase_in = whp_pkg::PH_FMT;
               end
               bad_in = 1'b0;
            end else idx_in = idx_ff + 5'd1;
         end
         whp_pkg::PH_FMT: begin
            if (idx_ff < 5'd4 && data_byte != whp_pkg::tag_byte(whp_pkg::TAG_FMT, idx_ff[1:0]))
               bad_in = 1'b1;
            if (idx_ff == 5'd7)  len_in = asm_in;
            if (idx_ff == 5'd9)  fmt_in = asm_in[31:16];
            if (idx_ff == 5'd11) ch_in = asm_in[31:16];
            if (idx_ff == 5'd15) rate_in = asm_in;
            if (idx_ff == 5'd19) brate_in = asm_in;
            if (idx_ff == 5'd21) align_in = asm_in[31:16];
            if (idx_ff >= 5'd23) begin
               width_w = (bits_w == 16'd8) ? 3'd1 : 3'd2;
               align_w = ch_ff[0] ? {1'b0, width_w} : {width_w, 1'b0};
               if (bad_ff) st = whp_pkg::ST_UNKNOWN;
               else if (!fmt_known) st = whp_pkg::ST_UNKNOWN;
               else if (ch_ff < 16'd1 || ch_ff > 16'd2) st = whp_pkg::ST_UNKNOWN;
               else if (len_ff < whp_pkg::FMT_BASE_LEN) st = whp_pkg::ST_INVALID;
               else if (rate_bad_ff) st = whp_pkg::ST_UNKNOWN;
               else if (align_ff < 16'd1 || align_ff > 16'd4 || (bits_w != 16'd8 &&
                        bits_w != 16'd12 && bits_w != 16'd16)) st = whp_pkg::ST_UNKNOWN;
               else if (brate_bad_ff || align_ff != {12'd0, align_w}) st = whp_pkg::ST_INVALID;
               idx_in = 5'd0;
               bad_in = 1'b0;
               if (st != whp_pkg::ST_OK) produced = 1'b1;
               else if (len_ff > whp_pkg::FMT_BASE_LEN) begin
                  skip_in = len_ff - whp_pkg::FMT_BASE_LEN;
                  phase_in = whp_pkg::PH_FMT_SKIP;
               end else phase_in = whp_pkg::PH_CHUNK_HDR;
               align_in = {12'd0, align_w};
               fmt_in = fmt_ff;
               // Keep bits in the channel register's spare upper byte.
               ch_in = {bits_w[7:0], ch_ff[7:0]};
            end else idx_in = idx_ff + 5'd1;
         end
         whp_pkg::PH_FMT_SKIP, whp_pkg::PH_CHUNK_SKIP: begin
            if (skip_ff != 32'd0) skip_in = skip_ff - 32'd1;
            if (skip_in == 32'd0) begin
               phase_in = whp_pkg::PH_CHUNK_HDR; idx_in = 5'd0; bad_in = 1'b0;
            end
         end
         whp_pkg::PH_CHUNK_HDR: begin
            if (idx_ff < 5'd4 && data_byte != whp_pkg::tag_byte(whp_pkg::TAG_DATA, idx_ff[1:0]))
               bad_in = 1'b1;
            if (idx_ff >= 5'd7) begin
               len_in = asm_in; len_w = asm_in; idx_in = 5'd0;
               if (bad_in) begin
                  bad_in = 1'b0; skip_in = asm_in;
                  phase_in = (asm_in != 32'd0) ? whp_pkg::PH_CHUNK_SKIP : whp_pkg::PH_CHUNK_HDR;
               end else begin
                  // Alignment is 1, 2 or 4 here, so the remainder is a mask.
                  rem = asm_in[1:0] & {align_ff[2], align_ff[2] | align_ff[1]};
                  produced = 1'b1;
                  st = (asm_in == 32'd0 || rem != 2'd0) ? whp_pkg::ST_INVALID : whp_pkg::ST_OK;
               end
            end else idx_in = idx_ff + 5'd1;
         end
         default: begin
         end
      endcase
      if (produced) phase_in = whp_pkg::PH_DONE;
      if (last_byte && !produced && phase_ff != whp_pkg::PH_DONE) begin
         produced = 1'b1; st = whp_pkg::ST_EARLY;
      end
      if (last_byte) begin
         phase_in = whp_pkg::PH_RIFF; idx_in = 5'd0; asm_in = 32'd0; len_in = 32'd0;
         fmt_in = 16'd0; ch_in = 16'd0; rate_in = 32'd0; brate_in = 32'd0;
         align_in = 16'd0; skip_in = 32'd0; pos_in = 32'd0; bad_in = 1'b0;
      end
   end

   assign res_valid = fire && produced;
   always_comb begin
      res_word = '0;
      res_word.status = st;
      if (st == whp_pkg::ST_OK) begin
         res_word.format_code = fmt_ff;
         res_word.channels = ch_ff[1:0];
         res_word.rate = rate_ff;
         res_word.bits = ch_ff[12:8];
         res_word.offset = pos_ff + 32'd1;
         res_word.length = len_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= whp_pkg::PH_RIFF; idx_ff <= '0; asm_ff <= '0; len_ff <= '0;
         fmt_ff <= '0; ch_ff <= '0; rate_ff <= '0; brate_ff <= '0; align_ff <= '0;
         skip_ff <= '0; pos_ff <= '0; bad_ff <= 1'b0;
         rate_bad_ff <= 1'b0; brate_bad_ff <= 1'b0;
      end else begin
         rate_bad_ff <= rate_bad_in; brate_bad_ff <= brate_bad_in;
         if (fire) begin
            phase_ff <= phase_in; idx_ff <= idx_in; asm_ff <= asm_in; len_ff <= len_in;
            fmt_ff <= fmt_in; ch_ff <= ch_in; rate_ff <= rate_in; brate_ff <= brate_in;
            align_ff <= align_in; skip_ff <= skip_in; pos_ff <= pos_in; bad_ff <= bad_in;
         end
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= 5'd23) else $error("field index out of range");
   a_done_idx: assert property (@(posedge clock) disable iff (reset)
      phase_ff == whp_pkg::PH_DONE |-> idx_ff == 5'd0) else $error("index not cleared");
   a_res_last: assert property (@(posedge clock) disable iff (reset)
      fire && last_byte && phase_ff != whp_pkg::PH_DONE |-> res_valid)
      else $error("early end without result");
endmodule

// ===== rtl/whp_back.sv =====
// Result queue and formatting: stores raw words and builds the output fields.
module whp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   input  whp_pkg::result_type res_word,
   output logic                res_full,
   output logic                out_valid,
   input  logic                out_stall,
   output logic [1:0]          status,
   output logic [2:0]          sample_format,
   output logic [1:0]          channel_count,
   output logic [31:0]         sample_rate,
   output logic [4:0]          bits_per_sample,
   output logic [31:0]         sample_start,
   output logic [31:0]         value_count
);
   whp_pkg::result_type q_ff [whp_pkg::QDEPTH];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;
   whp_pkg::result_type h;
   logic        alaw, ulaw;

   assign res_full = cnt_ff == 2'(whp_pkg::QDEPTH);
   assign push = res_valid && !res_full;
   assign out_valid = cnt_ff != 2'd0;
   assign pop = out_valid && !out_stall;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= res_word;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_in;
      end
   end

   assign h = q_ff[rp_ff];
   assign alaw = (h.format_code == whp_pkg::FMT_ALAW_A) ||
      (h.format_code == whp_pkg::FMT_ALAW_B);
   assign ulaw = (h.format_code == whp_pkg::FMT_ULAW_A) ||
      (h.format_code == whp_pkg::FMT_ULAW_B);

   always_comb begin
      status = h.status;
      channel_count = h.channels;
      sample_rate = h.rate;
      bits_per_sample = h.bits;
      sample_start = h.offset;
      sample_format = 3'd0;
      value_count = 32'd0;
      if (h.status == whp_pkg::ST_OK) begin
         if (h.bits == 5'd8) begin
            sample_format = alaw ? 3'd0 : (ulaw ? 3'd1 : 3'd2);
            value_count = h.length;
         end else begin
            sample_format = (h.bits == 5'd12) ? 3'd3 : 3'd4;
            value_count = {1'b0, h.length[31:1]};
         end
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(whp_pkg::QDEPTH)) else $error("queue overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_stall |=> out_valid) else $error("result dropped");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff) else $error("pointer mismatch");
endmodule

// ===== rtl/wav_header_parser_unit.sv =====
// Top level of the RIFF/WAVE header parser.
//  channel | ports                          | direction
//  req     | req_valid/req_stall, byte,last | in
//  rsp     | rsp_valid/rsp_stall, 7 fields  | out
//  csr     | csr_write_enable/index/data    | in
// One byte a cycle while the input is not stalled; the parser state register is the only loop.
// A result is written into a two-word queue with its final byte and leaves from there.
// Input stalls only while that queue is full.
// Reset is synchronous and restores the rate limits to 1378 and 96000.
module wav_header_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_sample_format,
   output logic [1:0]  rsp_channel_count,
   output logic [31:0] rsp_sample_rate,
   output logic [4:0]  rsp_bits_per_sample,
   output logic [31:0] rsp_sample_start,
   output logic [31:0] rsp_value_count,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   logic [31:0] min_ff, max_ff;
   logic res_valid, res_full;
   whp_pkg::result_type res_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= whp_pkg::MIN_RATE_RESET; max_ff <= whp_pkg::MAX_RATE_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == whp_pkg::CSR_MIN_RATE) min_ff <= csr_data;
         else max_ff <= csr_data;
      end
   end

   whp_front u_front (.clock, .reset, .in_valid(req_valid), .in_stall(req_stall),
      .data_byte(req_data_byte), .last_byte(req_last_byte), .min_rate(min_ff),
      .max_rate(max_ff), .res_valid, .res_word, .res_full);

   whp_back u_back (.clock, .reset, .res_valid, .res_word, .res_full,
      .out_valid(rsp_valid), .out_stall(rsp_stall), .status(rsp_status),
      .sample_format(rsp_sample_format), .channel_count(rsp_channel_count),
      .sample_rate(rsp_sample_rate), .bits_per_sample(rsp_bits_per_sample),
      .sample_start(rsp_sample_start), .value_count(rsp_value_count));
endmodule
